FILE: src/kabt_pkg.sv
// Package: shared constants and types of the keyed amount balance table.
`default_nettype none
package kabt_pkg;
   localparam int TableEntriesDefault = 256;
   localparam int KeyWidth = 64;
   localparam int AmountWidth = 64;
   localparam int CountOutWidth = 9;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_CREDIT = 2'd1,
      OP_DEBIT  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_OVERFLOW     = 3'd1,
      ST_FULL         = 3'd2,
      ST_NOT_FOUND    = 3'd3,
      ST_INSUFFICIENT = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_BAL,
      S_UPDATE,
      S_RESP
   } state_type;
endpackage
`default_nettype wire

FILE: src/kabt_if.sv
// Interfaces: request and response channels of the balance table.
`default_nettype none
interface kabt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] key_word0;
   logic [63:0] key_word1;
   logic [63:0] key_word2;
   logic [63:0] key_word3;
   logic [63:0] amount_low;
   logic [63:0] amount_high;
   modport source (output valid, op, key_word0, key_word1, key_word2, key_word3,
                   amount_low, amount_high, input ready);
   modport sink (input valid, op, key_word0, key_word1, key_word2, key_word3,
                 amount_low, amount_high, output ready);
endinterface

interface kabt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [63:0] left_low;
   logic [63:0] left_high;
   logic [8:0]  entries_used;
   modport source (output valid, status, left_low, left_high, entries_used,
                   input ready);
   modport sink (input valid, status, left_low, left_high, entries_used,
                 output ready);
endinterface
`default_nettype wire

FILE: src/keyed_amount_balance_table.sv
// Top level: keyed amount balance table with memory-resident keys and amounts.
// Each credit or debit scans the stored identifiers from entry 0, one entry per
// cycle through the key memory's single read port, until the first match or the
// fill count; a clear or no-op skips the scan. The amount memory is then read,
// updated and written back. Entries at or above the fill count are never taken
// as a match, so no clearing pass is needed. One item is in flight at a time;
// the result sits in an output register.
`default_nettype none
module keyed_amount_balance_table #(
   parameter int TABLE_ENTRIES = kabt_pkg::TableEntriesDefault
) (
   input  wire logic  clock,
   input  wire logic  reset,
   kabt_req_if.sink   req,
   kabt_rsp_if.source rsp
);
   localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CntW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CntW-1:0] CntMax = CntW'(TABLE_ENTRIES);

   logic [255:0] key_mem [TABLE_ENTRIES];
   logic [127:0] bal_mem [TABLE_ENTRIES];

   kabt_pkg::state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [IdxW-1:0] hit_ff, hit_in;
   logic [1:0]      op_ff;
   logic [255:0]    key_ff;
   logic [127:0]    amt_ff;
   logic [255:0]    key_rd_ff;
   logic [127:0]    bal_rd_ff;
   logic            rd_valid_ff, rd_valid_in;
   logic [2:0]      status_ff, status_in;
   logic [127:0]    left_ff, left_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            key_we, bal_we;
   logic [IdxW-1:0] key_ra, bal_addr;
   logic [127:0]    bal_wd;
   logic            accept;
   logic [128:0]    sum;
   logic [128:0]    diff;

   assign accept = req.valid && req.ready;
   assign sum  = {1'b0, bal_rd_ff} + {1'b0, amt_ff};
   assign diff = {1'b0, bal_rd_ff} - {1'b0, amt_ff};
   assign key_ra = scan_ff[IdxW-1:0];

   always_ff @(posedge clock) begin
      if (key_we) key_mem[count_ff[IdxW-1:0]] <= key_ff;
      key_rd_ff <= key_mem[key_ra];
   end

   always_ff @(posedge clock) begin
      if (bal_we) bal_mem[bal_addr] <= bal_wd;
      bal_rd_ff <= bal_mem[bal_addr];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kabt_pkg::S_IDLE: begin
            if (accept) begin
               if (req.op == kabt_pkg::OP_CREDIT || req.op == kabt_pkg::OP_DEBIT)
                  state_in = kabt_pkg::S_SCAN;
               else
                  state_in = kabt_pkg::S_RESP;
            end
         end
         kabt_pkg::S_SCAN: state_in = kabt_pkg::S_CHECK;
         kabt_pkg::S_CHECK: begin
            // key word at scan_ff-1 is in key_rd_ff when rd_valid_ff
            if (rd_valid_ff && key_rd_ff == key_ff) state_in = kabt_pkg::S_BAL;
            else if (scan_ff >= count_ff && !(scan_ff < count_ff))
               state_in = (rd_valid_ff && key_rd_ff == key_ff) ? kabt_pkg::S_BAL
                                                               : kabt_pkg::S_UPDATE;
         end
         kabt_pkg::S_BAL: state_in = kabt_pkg::S_UPDATE;
         kabt_pkg::S_UPDATE: state_in = kabt_pkg::S_RESP;
         kabt_pkg::S_RESP: if (!rsp_valid_ff || rsp.ready) state_in = kabt_pkg::S_IDLE;
         default: state_in = kabt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      rd_valid_in  = 1'b0;
      status_in    = status_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      key_we       = 1'b0;
      bal_we       = 1'b0;
      bal_addr     = hit_ff;
      bal_wd       = amt_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         kabt_pkg::S_IDLE: begin
            scan_in = '0;
            if (accept) begin
               status_in = kabt_pkg::ST_OK;
               left_in   = '0;
               if (req.op == kabt_pkg::OP_CLEAR) count_in = '0;
            end
         end
         kabt_pkg::S_SCAN: begin
            rd_valid_in = (scan_ff < count_ff);
            if (scan_ff < count_ff) scan_in = scan_ff + 1'b1;
         end
         kabt_pkg::S_CHECK: begin
            if (rd_valid_ff && key_rd_ff == key_ff) begin
               hit_in = IdxW'(scan_ff - 1'b1);
               bal_addr = IdxW'(scan_ff - 1'b1);
            end else begin
               rd_valid_in = (scan_ff < count_ff);
               if (scan_ff < count_ff) scan_in = scan_ff + 1'b1;
               else hit_in = count_ff[IdxW-1:0];
            end
         end
         kabt_pkg::S_BAL: begin
            // amount read issued in S_CHECK arrives now; mark hit
            rd_valid_in = 1'b1;
         end
         kabt_pkg::S_UPDATE: begin
            if (rd_valid_ff) begin
               if (op_ff == kabt_pkg::OP_CREDIT) begin
                  if (sum[128]) begin
                     status_in = kabt_pkg::ST_OVERFLOW;
                     left_in   = bal_rd_ff;
                  end else begin
                     bal_we  = 1'b1;
                     bal_wd  = sum[127:0];
                     left_in = sum[127:0];
                  end
               end else if (diff[128]) begin
                  status_in = kabt_pkg::ST_INSUFFICIENT;
                  left_in   = bal_rd_ff;
               end else begin
                  bal_we  = 1'b1;
                  bal_wd  = diff[127:0];
                  left_in = diff[127:0];
               end
            end else if (op_ff == kabt_pkg::OP_DEBIT) begin
               status_in = kabt_pkg::ST_NOT_FOUND;
            end else if (count_ff >= CntMax) begin
               status_in = kabt_pkg::ST_FULL;
            end else begin
               key_we   = 1'b1;
               bal_we   = 1'b1;
               bal_addr = count_ff[IdxW-1:0];
               bal_wd   = amt_ff;
               left_in  = amt_ff;
               count_in = count_ff + 1'b1;
            end
         end
         kabt_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kabt_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
      left_ff   <= left_in;
      if (accept) begin
         op_ff  <= req.op;
         key_ff <= {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
         amt_ff <= {req.amount_high, req.amount_low};
      end
   end

   logic [2:0]      rsp_status_ff;
   logic [127:0]    rsp_left_ff;
   logic [CntW-1:0] rsp_count_ff;
   always_ff @(posedge clock) begin
      if (state_ff == kabt_pkg::S_RESP && (!rsp_valid_ff || rsp.ready)) begin
         rsp_status_ff <= status_ff;
         rsp_left_ff   <= left_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign req.ready        = (state_ff == kabt_pkg::S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.left_low     = rsp_left_ff[63:0];
   assign rsp.left_high    = rsp_left_ff[127:64];
   assign rsp.entries_used = 9'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntMax) else $error("entry count above table depth");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      key_we |-> bal_we && state_ff == kabt_pkg::S_UPDATE)
      else $error("key written without amount");
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      key_we |=> count_ff == $past(count_ff) + 1'b1) else $error("insert count");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_left_ff))
      else $error("result dropped");
endmodule
`default_nettype wire

FILE: tb/tb_keyed_amount_balance_table.sv
// Testbench: keyed amount balance table checked against an in-bench ledger predictor.
`timescale 1ns / 1ps
module tb_keyed_amount_balance_table;

   localparam int Depth = kabt_pkg::TableEntriesDefault;

   typedef struct packed {
      kabt_pkg::status_type status;
      logic [63:0]          left_low;
      logic [63:0]          left_high;
      logic [8:0]           entries_used;
   } balance_rsp_type;

   // ledger predictor plus queue of expected responses
   class ledger_board;
      logic [255:0]    keys[Depth];
      logic [127:0]    amounts[Depth];
      int              used;
      balance_rsp_type pending[$];
      int              errors;
      int              checked;

      function void note_request(kabt_pkg::op_type op, logic [255:0] key,
                                 logic [127:0] amt);
         balance_rsp_type r;
         int              idx;
         logic [128:0]    total;
         r = '{kabt_pkg::ST_OK, 64'd0, 64'd0, 9'd0};
         idx = used;
         for (int i = 0; i < used; i++) begin
            if (keys[i] == key) begin
               idx = i;
               break;
            end
         end
         case (op)
            kabt_pkg::OP_CLEAR: used = 0;
            kabt_pkg::OP_CREDIT: begin
               if (idx < used) begin
                  total = {1'b0, amounts[idx]} + {1'b0, amt};
                  if (total[128]) begin
                     r.status = kabt_pkg::ST_OVERFLOW;
                  end else begin
                     amounts[idx] = total[127:0];
                  end
                  {r.left_high, r.left_low} = amounts[idx];
               end else if (used >= Depth) begin
                  r.status = kabt_pkg::ST_FULL;
               end else begin
                  keys[used] = key;
                  amounts[used] = amt;
                  used++;
                  {r.left_high, r.left_low} = amt;
               end
            end
            kabt_pkg::OP_DEBIT: begin
               if (idx >= used) begin
                  r.status = kabt_pkg::ST_NOT_FOUND;
               end else begin
                  if (amounts[idx] < amt) begin
                     r.status = kabt_pkg::ST_INSUFFICIENT;
                  end else begin
                     amounts[idx] = amounts[idx] - amt;
                  end
                  {r.left_high, r.left_low} = amounts[idx];
               end
            end
            default: ;
         endcase
         r.entries_used = used[8:0];
         pending.push_back(r);
      endfunction

      function void check_response(balance_rsp_type got);
         balance_rsp_type want;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response %p", $time, got);
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         if (got.left_low !== want.left_low)
            $display("%0t: left_low expected %h got %h", $time, want.left_low, got.left_low);
         if (got.left_high !== want.left_high)
            $display("%0t: left_high expected %h got %h", $time, want.left_high,
                     got.left_high);
         if (got.entries_used !== want.entries_used)
            $display("%0t: entries_used expected %0d got %0d", $time, want.entries_used,
                     got.entries_used);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock;
   logic reset;
   kabt_req_if req ();
   kabt_rsp_if rsp ();

   keyed_amount_balance_table uut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   ledger_board board;
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int          sent;
   logic [255:0] key_pool[16];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver: sample at rising edge, drive ready at falling edge
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_response('{kabt_pkg::status_type'(rsp.status), rsp.left_low,
                                rsp.left_high, rsp.entries_used});
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // leaves valid high; the caller drops it once no beat follows
   task automatic send_item(kabt_pkg::op_type op, logic [255:0] key, logic [127:0] amt);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.op <= op;
      {req.key_word3, req.key_word2, req.key_word1, req.key_word0} <= key;
      {req.amount_high, req.amount_low} <= amt;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_request(op, key, amt);
      sent++;
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [127:0] rand_amount();
      case ($urandom_range(5))
         0: return '1;
         1: return 128'd0;
         2: return {64'd0, rand64()};
         3: return {rand64(), rand64()};
         default: return {96'd0, $urandom_range(1000)};
      endcase
   endfunction

   task automatic drain();
      int guard;
      guard = 0;
      req.valid <= 1'b0;
      while (board.pending.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (Depth + 10) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      kabt_pkg::op_type op;
      logic [255:0]     key;
      int               pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         op = (pick < 50) ? kabt_pkg::OP_CREDIT : (pick < 90) ? kabt_pkg::OP_DEBIT :
              (pick < 95) ? kabt_pkg::OP_NONE : kabt_pkg::OP_CLEAR;
         key = ($urandom_range(9) == 0) ? {rand64(), rand64(), rand64(), rand64()}
                                        : key_pool[$urandom_range(15)];
         send_item(op, key, rand_amount());
      end
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req.valid = 1'b0;
      req.op = kabt_pkg::OP_CLEAR;
      {req.key_word0, req.key_word1, req.key_word2, req.key_word3} = '0;
      {req.amount_low, req.amount_high} = '0;
      rsp.ready = 1'b0;
      for (int i = 0; i < 16; i++) key_pool[i] = {rand64(), rand64(), rand64(), rand64()};
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {64'd0, 64'd0, 64'd0, 64'd1};   // differs only in last word
      key_pool[3] = {64'd1, 64'd0, 64'd0, 64'd0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edges, overflow, insufficient, not found, zero credit, op three
      send_item(kabt_pkg::OP_DEBIT, key_pool[0], 128'd1);
      send_item(kabt_pkg::OP_CREDIT, key_pool[0], 128'd0);
      send_item(kabt_pkg::OP_CREDIT, key_pool[1], '1);
      send_item(kabt_pkg::OP_CREDIT, key_pool[1], 128'd1);
      send_item(kabt_pkg::OP_CREDIT, key_pool[2], {64'd0, {64{1'b1}}});
      send_item(kabt_pkg::OP_CREDIT, key_pool[2], 128'd1);
      send_item(kabt_pkg::OP_CREDIT, key_pool[3], {{64{1'b1}}, 64'd0});
      send_item(kabt_pkg::OP_CREDIT, key_pool[3], {64'd1, 64'd0});
      send_item(kabt_pkg::OP_DEBIT, key_pool[2], {64'd2, 64'd0});
      send_item(kabt_pkg::OP_DEBIT, key_pool[2], 128'd1);
      send_item(kabt_pkg::OP_DEBIT, key_pool[2], {64'd0, {64{1'b1}}});
      send_item(kabt_pkg::OP_DEBIT, key_pool[1], '1);
      send_item(kabt_pkg::OP_DEBIT, key_pool[1], 128'd1);
      send_item(kabt_pkg::OP_NONE, key_pool[1], '1);
      send_item(kabt_pkg::OP_CLEAR, '1, '1);
      send_item(kabt_pkg::OP_DEBIT, key_pool[1], 128'd0);
      drain();

      // fill the table to capacity, then hit table full
      for (int i = 0; i < Depth; i++)
         send_item(kabt_pkg::OP_CREDIT, {rand64(), rand64(), 64'(i), 64'hA5A5},
                   {64'd0, 64'(i)});
      send_item(kabt_pkg::OP_CREDIT, key_pool[5], 128'd7);
      send_item(kabt_pkg::OP_DEBIT, {rand64(), rand64(), 64'(Depth - 1), 64'hA5A5},
                128'd0);
      send_item(kabt_pkg::OP_CLEAR, '0, '0);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         random_phase(8);
      join

      random_phase(90);
      send_idle_pct = 68;
      random_phase(90);
      send_idle_pct = 0;
      recv_stall_pct = 68;
      random_phase(90);
      send_idle_pct = 28;
      recv_stall_pct = 28;
      random_phase(90);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_phase(40);
      drain();

      $display("Run covered %0d requests and %0d responses across idle and stall mixes,",
               sent, board.checked);
      $display("including a full table, overflow, insufficient and missing-key beats.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
